/* rtl/ship_rrip_replacement_unit_macros.svh */
// assertion macros shared by the replacement unit rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef SHIP_RRIP_REPLACEMENT_UNIT_MACROS_SVH
`define SHIP_RRIP_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication
`define SRRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srru_pkg.sv */
// shared types and constants of the ship rrip replacement unit
// no dependencies
package srru_pkg;

    localparam int REQ_W  = 3;
    localparam int SETI_W = 11;
    localparam int WAY_W  = 4;
    localparam int ADDR_W = 48;
    localparam int PC_W   = 32;
    localparam int ACT_W  = 2;

    localparam int REQ_LSB  = 0;
    localparam int SET_LSB  = REQ_LSB + REQ_W;
    localparam int WAY_LSB  = SET_LSB + SETI_W;
    localparam int ADDR_LSB = WAY_LSB + WAY_W;
    localparam int PC_LSB   = ADDR_LSB + ADDR_W;
    localparam int WR_LSB   = PC_LSB + PC_W;
    localparam int HIT_LSB  = WR_LSB + 1;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 8;

    localparam int DEF_SETS        = 2048;
    localparam int DEF_WAYS        = 16;
    localparam int DEF_CONSUMERS   = 1;
    localparam int DEF_SAMPLE_RATE = 32;
    localparam int DEF_SIG_MODULUS = 16381;
    localparam int DEF_OFFSET_BITS = 6;

    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [1:0] CTR_MAX  = 2'd3;

    typedef enum logic [1:0] {
        ACT_VICTIM = 2'd0,
        ACT_ACCESS = 2'd1,
        ACT_FILL   = 2'd2,
        ACT_NONE   = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_QUOT,
        ST_READ,
        ST_EVAL,
        ST_CTR_RD,
        ST_CTR_WR
    } t_state;

    typedef struct packed {
        logic rrpv;
        logic samp;
        logic ctr;
    } t_mem_we;

endpackage

/* rtl/srru_divc.sv */
// divider by a constant through reciprocal multiplication and one correction step
// uses no package
module srru_divc #(
    parameter int W = 32,
    parameter int D = 3,
    localparam int RW = $clog2(D + 1) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    output logic          o_busy,
    output logic [W-1:0]  o_quot,
    output logic [RW-1:0] o_rem
);
    localparam int       PRW   = 2 * W + 1;
    localparam logic [W:0] RECIP = (W + 1)'((64'd1 << W) / 64'(D));
    localparam logic [W-1:0] DW  = W'(D);

    logic [1:0]     r_cnt;
    logic [W-1:0]   r_x;
    logic [PRW-1:0] r_prod;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_r;
    logic [W-1:0]   qe;

    // estimate is the true quotient or one below it
    assign qe = r_prod[W +: W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 2'd3;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_cnt == 2'd3) begin
            r_prod <= PRW'(r_x) * PRW'(RECIP);
        end
        if (r_cnt == 2'd2) begin
            r_q <= qe;
            r_r <= r_x - qe * DW;
        end
        if (r_cnt == 2'd1 && 64'(r_r) >= 64'(D)) begin
            r_q <= r_q + W'(1);
            r_r <= r_r - DW;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
    assign o_rem  = RW'(r_r);
endmodule

/* rtl/srru_store.sv */
// rrpv, sampler and outcome counter memories with the clearing sweep after reset
// depends on srru_pkg
module srru_store #(
    parameter int SETS   = 2048,
    parameter int WAYS   = 16,
    parameter int SROWS  = 64,
    parameter int CDEPTH = 16381,
    parameter int EW     = 62,
    parameter int RK_O   = 2,
    parameter int WB     = 4,
    localparam int RAW = $clog2(SETS),
    localparam int SAW = (SROWS > 1) ? $clog2(SROWS) : 1,
    localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  srru_pkg::t_mem_we      i_we,
    input  logic [RAW-1:0]         i_rrpv_addr,
    input  logic [WAYS*2-1:0]      i_rrpv_wdata,
    output logic [WAYS*2-1:0]      o_rrpv_rdata,
    input  logic [SAW-1:0]         i_samp_addr,
    input  logic [WAYS*EW-1:0]     i_samp_wdata,
    output logic [WAYS*EW-1:0]     o_samp_rdata,
    input  logic [CAW-1:0]         i_ctr_addr,
    input  logic [1:0]             i_ctr_wdata,
    output logic [1:0]             o_ctr_rdata,
    output logic                   o_busy
);
    import srru_pkg::*;

    localparam int MAXA = (SETS > SROWS) ? SETS : SROWS;
    localparam int MAXD = (MAXA > CDEPTH) ? MAXA : CDEPTH;
    localparam int CW   = $clog2(MAXD + 1);

    logic [WAYS*2-1:0]  rrpv_mem [SETS];
    logic [WAYS*EW-1:0] samp_mem [SROWS];
    logic [1:0]         ctr_mem  [CDEPTH];

    logic          r_clearing;
    logic [CW-1:0] r_clr_cnt;

    function automatic logic [WAYS*EW-1:0] samp_init();
        logic [WAYS*EW-1:0] v;
        v = '0;
        for (int i = 0; i < WAYS; i++) begin
            v[i*EW+RK_O +: WB] = WB'(i);
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == CW'(MAXD - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing && r_clr_cnt < CW'(SETS)) begin
            rrpv_mem[r_clr_cnt[RAW-1:0]] <= '1;
        end else if (i_we.rrpv) begin
            rrpv_mem[i_rrpv_addr] <= i_rrpv_wdata;
        end
        o_rrpv_rdata <= rrpv_mem[i_rrpv_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing && r_clr_cnt < CW'(SROWS)) begin
            samp_mem[r_clr_cnt[SAW-1:0]] <= samp_init();
        end else if (i_we.samp) begin
            samp_mem[i_samp_addr] <= i_samp_wdata;
        end
        o_samp_rdata <= samp_mem[i_samp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing && r_clr_cnt < CW'(CDEPTH)) begin
            ctr_mem[r_clr_cnt[CAW-1:0]] <= '0;
        end else if (i_we.ctr) begin
            ctr_mem[i_ctr_addr] <= i_ctr_wdata;
        end
        o_ctr_rdata <= ctr_mem[i_ctr_addr];
    end

    assign o_busy = r_clearing;
endmodule

/* rtl/ship_rrip_replacement_unit.sv */
// top level of the ship rrip replacement unit: request sequencer and set logic
// depends on srru_pkg, srru_divc, srru_store and the macros header
// One request at a time. After reset the unit sweeps its memories over
// max(SETS, sampler rows, CONSUMERS*SIG_MODULUS) entries (16381 by default) with
// tready low. A request then holds tready low through the pc signature and set
// reductions, which run in parallel, the sampled-set reduction, a memory read
// state and an evaluate/write state, after which the next request is accepted;
// an access update that trains an outcome counter adds a counter read-modify-write,
// and a request with the unknown action is accepted and leaves the unit idle.
// A find victim result sits in an output register until taken, and a following
// find victim waits in its evaluate cycle while that register is full.
`include "ship_rrip_replacement_unit_macros.svh"
module ship_rrip_replacement_unit #(
    parameter int SETS        = srru_pkg::DEF_SETS,
    parameter int WAYS        = srru_pkg::DEF_WAYS,
    parameter int CONSUMERS   = srru_pkg::DEF_CONSUMERS,
    parameter int SAMPLE_RATE = srru_pkg::DEF_SAMPLE_RATE,
    parameter int SIG_MODULUS = srru_pkg::DEF_SIG_MODULUS,
    parameter int OFFSET_BITS = srru_pkg::DEF_OFFSET_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // requester, set_index, way_index, address, pc, is_write, was_hit, zero pad
    input  logic [srru_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // action
    input  logic [srru_pkg::ACT_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // victim_way, zero pad
    output logic [srru_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import srru_pkg::*;

    localparam int WB     = $clog2(WAYS);
    localparam int SETW   = $clog2(SETS);
    localparam int NSAMP  = (SETS + SAMPLE_RATE - 1) / SAMPLE_RATE;
    localparam int SROWS  = NSAMP * CONSUMERS;
    localparam int SAW    = (SROWS > 1) ? $clog2(SROWS) : 1;
    localparam int CDEPTH = CONSUMERS * SIG_MODULUS;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SGW    = $clog2(SIG_MODULUS);
    localparam int TW     = ADDR_W - OFFSET_BITS;
    localparam int VA_O   = 0;
    localparam int RU_O   = 1;
    localparam int RK_O   = 2;
    localparam int SG_O   = RK_O + WB;
    localparam int TG_O   = SG_O + SGW;
    localparam int EW     = TG_O + TW;
    localparam int SIGRW  = $clog2(SIG_MODULUS + 1) + 1;
    localparam int SETRW  = $clog2(SETS + 1) + 1;
    localparam int SMPRW  = $clog2(SAMPLE_RATE + 1) + 1;

    t_state r_state, n_state;
    t_act   a_act, r_act;

    logic             acc;
    logic [REQ_W-1:0] r_req;
    logic [WAY_W-1:0] r_way;
    logic [TW-1:0]    r_tag;
    logic             r_is_write, r_was_hit;
    logic [CAW-1:0]   r_caddr, n_caddr;
    logic             r_cdec, n_cdec;
    logic             r_ovalid, n_ovalid;
    logic [WAY_W-1:0] r_vway, n_vway;

    logic              sig_busy, set_busy, smp_busy, smp_start;
    logic [PC_W-1:0]   sig_quot;
    logic [SIGRW-1:0]  sig_rem;
    logic [SETI_W-1:0] set_quot;
    logic [SETRW-1:0]  set_rem;
    logic [SETW-1:0]   smp_quot;
    logic [SMPRW-1:0]  smp_rem;
    logic [SGW-1:0]    sig;
    logic [SETW-1:0]   set_idx;
    logic [SAW-1:0]    srow;
    logic              sampled;

    t_mem_we            we;
    logic [WAYS*2-1:0]  rrpv_rdata, rrpv_wdata;
    logic [WAYS*EW-1:0] samp_rdata, samp_wdata;
    logic [1:0]         ctr_rdata, ctr_wdata;
    logic               clr_busy;

    logic [1:0]    rv      [WAYS];
    logic          s_valid [WAYS];
    logic          s_reused[WAYS];
    logic [WB-1:0] s_rank  [WAYS];
    logic [SGW-1:0] s_sig  [WAYS];
    logic [TW-1:0] s_tag   [WAYS];

    logic              hit_found, lru_found;
    logic [WB-1:0]     hit_w, lru_w, tw, tr, rk, best, wi;
    logic              ctr_upd, way_ok, best_found;
    logic [SGW-1:0]    tsig;
    logic [1:0]        maxv, addv, fillv;
    logic [WAYS*2-1:0] aged_row, hit_row, fill_row;

    function automatic logic [REQ_W-1:0] req_mod(input logic [REQ_W-1:0] v);
        logic [REQ_W:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= (REQ_W + 1)'(CONSUMERS)) begin
                t = t - (REQ_W + 1)'(CONSUMERS);
            end
        end
        return t[REQ_W-1:0];
    endfunction

    function automatic logic [CAW-1:0] ctr_addr(input logic [REQ_W-1:0] q,
                                                input logic [SGW-1:0] s);
        return CAW'(q) * CAW'(SIG_MODULUS) + CAW'(s);
    endfunction

    assign a_act = t_act'(i_s_axis_tuser);
    assign acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && !clr_busy;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(M_DATA_W - WAY_W)'(0), r_vway};

    srru_divc #(.W(PC_W), .D(SIG_MODULUS)) u_sig (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(acc),
        .i_dividend(i_s_axis_tdata[PC_LSB +: PC_W]),
        .o_busy(sig_busy), .o_quot(sig_quot), .o_rem(sig_rem)
    );

    srru_divc #(.W(SETI_W), .D(SETS)) u_set (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(acc),
        .i_dividend(i_s_axis_tdata[SET_LSB +: SETI_W]),
        .o_busy(set_busy), .o_quot(set_quot), .o_rem(set_rem)
    );

    srru_divc #(.W(SETW), .D(SAMPLE_RATE)) u_smp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(smp_start),
        .i_dividend(set_idx),
        .o_busy(smp_busy), .o_quot(smp_quot), .o_rem(smp_rem)
    );

    assign sig     = sig_rem[SGW-1:0];
    assign set_idx = set_rem[SETW-1:0];
    assign sampled = (smp_rem == '0);
    assign srow    = SAW'(smp_quot) + SAW'(NSAMP) * SAW'(r_req);
    assign smp_start = (r_state == ST_DIV) && !sig_busy && !set_busy;

    srru_store #(
        .SETS(SETS), .WAYS(WAYS), .SROWS(SROWS), .CDEPTH(CDEPTH),
        .EW(EW), .RK_O(RK_O), .WB(WB)
    ) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we),
        .i_rrpv_addr(set_idx), .i_rrpv_wdata(rrpv_wdata), .o_rrpv_rdata(rrpv_rdata),
        .i_samp_addr(srow), .i_samp_wdata(samp_wdata), .o_samp_rdata(samp_rdata),
        .i_ctr_addr(r_caddr), .i_ctr_wdata(ctr_wdata), .o_ctr_rdata(ctr_rdata),
        .o_busy(clr_busy)
    );

    // unpack the rows
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            rv[i]       = rrpv_rdata[2*i +: 2];
            s_valid[i]  = samp_rdata[i*EW+VA_O];
            s_reused[i] = samp_rdata[i*EW+RU_O];
            s_rank[i]   = samp_rdata[i*EW+RK_O +: WB];
            s_sig[i]    = samp_rdata[i*EW+SG_O +: SGW];
            s_tag[i]    = samp_rdata[i*EW+TG_O +: TW];
        end
    end

    // victim search and aging
    always_comb begin
        maxv = 2'd0;
        for (int i = 0; i < WAYS; i++) begin
            if (rv[i] > maxv) begin
                maxv = rv[i];
            end
        end
        best       = '0;
        best_found = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            if (!best_found && rv[i] == maxv) begin
                best_found = 1'b1;
                best       = WB'(i);
            end
        end
        addv = RRPV_MAX - rv[best];
        for (int i = 0; i < WAYS; i++) begin
            aged_row[2*i +: 2] = rv[i] + addv;
        end
    end

    // single-line rrpv updates
    always_comb begin
        way_ok   = int'(r_way) < WAYS;
        wi       = WB'(r_way);
        fillv    = (!r_is_write && ctr_rdata == CTR_MAX) ? RRPV_MAX : RRPV_MAX - 2'd1;
        hit_row  = rrpv_rdata;
        fill_row = rrpv_rdata;
        hit_row[int'(wi)*2 +: 2]  = 2'd0;
        fill_row[int'(wi)*2 +: 2] = fillv;
    end

    // sampler lookup, lru and row update
    always_comb begin
        hit_found = 1'b0;
        lru_found = 1'b0;
        hit_w     = '0;
        lru_w     = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!hit_found && s_valid[i] && s_tag[i] == r_tag) begin
                hit_found = 1'b1;
                hit_w     = WB'(i);
            end
            if (!lru_found && s_rank[i] == '0) begin
                lru_found = 1'b1;
                lru_w     = WB'(i);
            end
        end
        tw      = hit_found ? hit_w : lru_w;
        tr      = s_rank[tw];
        tsig    = s_sig[tw];
        ctr_upd = hit_found || (s_valid[tw] && !s_reused[tw]);
        samp_wdata = samp_rdata;
        for (int i = 0; i < WAYS; i++) begin
            rk = s_rank[i];
            if (rk > tr) begin
                rk = rk - 1'b1;
            end
            samp_wdata[i*EW+RK_O +: WB] = rk;
        end
        samp_wdata[int'(tw)*EW+RK_O +: WB] = WB'(WAYS - 1);
        if (hit_found) begin
            samp_wdata[int'(tw)*EW+RU_O] = 1'b1;
        end else begin
            samp_wdata[int'(tw)*EW+VA_O]        = 1'b1;
            samp_wdata[int'(tw)*EW+RU_O]        = 1'b0;
            samp_wdata[int'(tw)*EW+SG_O +: SGW] = sig;
            samp_wdata[int'(tw)*EW+TG_O +: TW]  = r_tag;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        we         = '0;
        rrpv_wdata = rrpv_rdata;
        ctr_wdata  = ctr_rdata;
        n_caddr    = r_caddr;
        n_cdec     = r_cdec;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_vway     = r_vway;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && a_act != ACT_NONE) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (smp_start) begin
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT: begin
                if (!smp_busy) begin
                    n_state = ST_READ;
                    n_caddr = ctr_addr(r_req, sig);
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                unique case (r_act)
                    ACT_VICTIM: begin
                        if (!r_ovalid || i_m_axis_tready) begin
                            we.rrpv    = 1'b1;
                            rrpv_wdata = aged_row;
                            n_ovalid   = 1'b1;
                            n_vway     = WAY_W'(best);
                            n_state    = ST_IDLE;
                        end
                    end
                    ACT_ACCESS: begin
                        we.samp = sampled;
                        if (r_was_hit && way_ok) begin
                            we.rrpv    = 1'b1;
                            rrpv_wdata = hit_row;
                        end
                        if (sampled && ctr_upd) begin
                            n_caddr = ctr_addr(r_req, tsig);
                            n_cdec  = hit_found;
                            n_state = ST_CTR_RD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    ACT_FILL: begin
                        if (way_ok) begin
                            we.rrpv    = 1'b1;
                            rrpv_wdata = fill_row;
                        end
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_CTR_RD: begin
                n_state = ST_CTR_WR;
            end
            ST_CTR_WR: begin
                we.ctr = 1'b1;
                if (r_cdec) begin
                    ctr_wdata = (ctr_rdata == 2'd0) ? 2'd0 : ctr_rdata - 2'd1;
                end else begin
                    ctr_wdata = (ctr_rdata == CTR_MAX) ? CTR_MAX : ctr_rdata + 2'd1;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_caddr <= n_caddr;
        r_cdec  <= n_cdec;
        r_vway  <= n_vway;
        if (acc) begin
            r_act      <= a_act;
            r_req      <= req_mod(i_s_axis_tdata[REQ_LSB +: REQ_W]);
            r_way      <= i_s_axis_tdata[WAY_LSB +: WAY_W];
            r_tag      <= i_s_axis_tdata[ADDR_LSB + OFFSET_BITS +: TW];
            r_is_write <= i_s_axis_tdata[WR_LSB];
            r_was_hit  <= i_s_axis_tdata[HIT_LSB];
        end
    end

    `SRRU_ASSERT_NEXT(a_acc_starts, acc && a_act != ACT_NONE, r_state == ST_DIV, "request not started")
    `SRRU_ASSERT_SAME(a_idle_in_clear, clr_busy, r_state == ST_IDLE, "work during clearing sweep")
    `SRRU_ASSERT_SAME(a_out_from_victim, $rose(o_m_axis_tvalid), $past(r_state) == ST_EVAL && $past(r_act) == ACT_VICTIM, "result without find victim")
    `SRRU_ASSERT_SAME(a_ctr_from_access, r_state == ST_CTR_RD || r_state == ST_CTR_WR, r_act == ACT_ACCESS, "counter update outside access")

endmodule
